/* hdl/kt_pkg.sv */
// kt_pkg: shared types and codes for the key table block
// operation codes, status codes and the sequencer state type
// no dependencies
`default_nettype none
package kt_pkg;

  typedef enum logic [2:0] {
    FN_APPEND = 3'd0,
    FN_READ   = 3'd1,
    FN_SEARCH = 3'd2,
    FN_REMOVE = 3'd3,
    FN_INSERT = 3'd4,
    FN_SORT   = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_FIND_RD,
    S_FIND_CMP,
    S_DN_RD,
    S_DN_WR,
    S_UP_RD,
    S_UP_WR,
    S_INS_WR,
    S_SORT_RD0,
    S_SORT_LD,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_LAST,
    S_DONE
  } state_e;

  typedef struct packed {
    logic        found;
    logic [5:0]  position;
    logic [31:0] value;
    logic [5:0]  count;
    logic [1:0]  status;
  } result_t;

endpackage
`default_nettype wire

/* hdl/key_table_insert_remove_sort_top.sv */
// key_table_insert_remove_sort_top: ordered table of signed 32-bit keys
// depends on kt_pkg and kt_ram
`default_nettype none
// usage:
// - one input transfer on the s_axis channel carries one operation, tuser
//   holds the operation code; one result transfer leaves on m_axis for each
// - keys live in a single ram with a registered read; a sequencer walks it
// - append writes the ram on acceptance; read waits for the registered read
// - search reads and compares one entry at a time; remove and insert then
//   move the later entries down or up; sort is a bubble sort: (count-1) passes
// - the ram port (one read, one write per cycle) paces all of these operations
// - the block takes a new operation whenever the sequencer is idle, even while
//   the previous result waits in the output register
// - a stalled receiver holds the result; a finished operation then waits
//   until the output register frees up
// - reset empties the table (count zero); ram contents are left as they are,
//   only entries below the count are ever read
module key_table_insert_remove_sort_top #(
  parameter int DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // key[31:0], new_key[63:32], index[68:64], clear_first[69], zero fill
  input  wire logic [71:0] s_axis_tdata_i,
  // func[2:0]
  input  wire logic [2:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // found[0], position[6:1], value[38:7], count[44:39], status[46:45], zero fill
  output logic [47:0]      m_axis_tdata_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  kt_pkg::state_e state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  j_q, j_d;
  logic [CW-1:0]  i_q, i_d;
  logic [CW-1:0]  pass_q, pass_d;
  logic [31:0]    cur_q, cur_d;
  logic [2:0]     func_q, func_d;
  logic [31:0]    key_q, key_d;
  logic [31:0]    nkey_q, nkey_d;
  kt_pkg::result_t res_q, res_d;
  kt_pkg::result_t out_q, out_d;
  logic           out_valid_q, out_valid_d;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [31:0]    wdata, rdata;
  logic           accept;
  logic [CW-1:0]  base_cnt;

  kt_ram #(.Width(32), .Depth(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign s_axis_tready_o = (state_q == kt_pkg::S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.status, out_q.count, out_q.value,
                            out_q.position, out_q.found};
  assign base_cnt = s_axis_tdata_i[69] ? '0 : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kt_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // operands and datapath registers
  always_ff @(posedge clk_i) begin
    j_q    <= j_d;
    i_q    <= i_d;
    pass_q <= pass_d;
    cur_q  <= cur_d;
    func_q <= func_d;
    key_q  <= key_d;
    nkey_q <= nkey_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    j_d         = j_q;
    i_d         = i_q;
    pass_d      = pass_q;
    cur_d       = cur_q;
    func_d      = func_q;
    key_d       = key_q;
    nkey_d      = nkey_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    we          = 1'b0;
    waddr       = j_q[AW-1:0];
    wdata       = rdata;
    raddr       = j_q[AW-1:0];

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      kt_pkg::S_IDLE: begin
        raddr = AW'(s_axis_tdata_i[68:64]);
        if (accept) begin
          func_d = s_axis_tuser_i;
          key_d  = s_axis_tdata_i[31:0];
          nkey_d = s_axis_tdata_i[63:32];
          j_d    = '0;
          pass_d = '0;
          res_d  = '0;
          state_d = kt_pkg::S_DONE;
          unique case (s_axis_tuser_i)
            kt_pkg::FN_APPEND: begin
              cnt_d = base_cnt;
              res_d.position = 6'(base_cnt);
              if (base_cnt >= DepthC) begin
                res_d.status = kt_pkg::ST_FULL;
              end else begin
                we    = 1'b1;
                waddr = base_cnt[AW-1:0];
                wdata = s_axis_tdata_i[31:0];
                res_d.value = s_axis_tdata_i[31:0];
                cnt_d = base_cnt + 1'b1;
              end
            end
            kt_pkg::FN_READ: begin
              res_d.position = 6'(s_axis_tdata_i[68:64]);
              if (32'(s_axis_tdata_i[68:64]) < 32'(cnt_q)) begin
                state_d = kt_pkg::S_RD_WAIT;
              end else begin
                res_d.status = kt_pkg::ST_RANGE;
              end
            end
            kt_pkg::FN_SEARCH, kt_pkg::FN_REMOVE, kt_pkg::FN_INSERT: begin
              if (cnt_q == '0) begin
                res_d.status = kt_pkg::ST_NOT_FOUND;
              end else begin
                state_d = kt_pkg::S_FIND_RD;
              end
            end
            kt_pkg::FN_SORT: begin
              if (cnt_q > CW'(1)) begin
                state_d = kt_pkg::S_SORT_RD0;
              end
            end
            default: ;
          endcase
        end
      end
      kt_pkg::S_RD_WAIT: begin
        res_d.value = rdata;
        state_d = kt_pkg::S_DONE;
      end
      kt_pkg::S_FIND_RD: begin
        state_d = kt_pkg::S_FIND_CMP;
      end
      kt_pkg::S_FIND_CMP: begin
        if (rdata == key_q) begin
          res_d.found    = 1'b1;
          res_d.position = 6'(j_q);
          res_d.value    = key_q;
          i_d = j_q;
          state_d = kt_pkg::S_DONE;
          if (func_q == kt_pkg::FN_REMOVE) begin
            if (j_q + 1'b1 < cnt_q) begin
              state_d = kt_pkg::S_DN_RD;
            end else begin
              cnt_d = cnt_q - 1'b1;
            end
          end else if (func_q == kt_pkg::FN_INSERT) begin
            if (cnt_q >= DepthC) begin
              res_d.status = kt_pkg::ST_FULL;
            end else begin
              j_d = cnt_q;
              state_d = kt_pkg::S_UP_RD;
            end
          end
        end else if (j_q + 1'b1 < cnt_q) begin
          j_d = j_q + 1'b1;
          state_d = kt_pkg::S_FIND_RD;
        end else begin
          res_d.status = kt_pkg::ST_NOT_FOUND;
          state_d = kt_pkg::S_DONE;
        end
      end
      // remove: entry j takes entry j+1
      kt_pkg::S_DN_RD: begin
        raddr = AW'(j_q + 1'b1);
        state_d = kt_pkg::S_DN_WR;
      end
      kt_pkg::S_DN_WR: begin
        we = 1'b1;
        if (j_q + 2'd2 < {1'b0, cnt_q}) begin
          j_d = j_q + 1'b1;
          state_d = kt_pkg::S_DN_RD;
        end else begin
          cnt_d = cnt_q - 1'b1;
          state_d = kt_pkg::S_DONE;
        end
      end
      // insert: entry j takes entry j-1, down to the match
      kt_pkg::S_UP_RD: begin
        raddr = AW'(j_q - 1'b1);
        state_d = kt_pkg::S_UP_WR;
      end
      kt_pkg::S_UP_WR: begin
        we = 1'b1;
        j_d = j_q - 1'b1;
        state_d = (j_q - 1'b1 > i_q) ? kt_pkg::S_UP_RD : kt_pkg::S_INS_WR;
      end
      kt_pkg::S_INS_WR: begin
        we    = 1'b1;
        waddr = i_q[AW-1:0];
        wdata = nkey_q;
        cnt_d = cnt_q + 1'b1;
        state_d = kt_pkg::S_DONE;
      end
      // sort: bubble passes, cur carries the largest key seen in the pass
      kt_pkg::S_SORT_RD0: begin
        raddr = '0;
        state_d = kt_pkg::S_SORT_LD;
      end
      kt_pkg::S_SORT_LD: begin
        cur_d = rdata;
        j_d   = CW'(1);
        state_d = kt_pkg::S_SORT_RD;
      end
      kt_pkg::S_SORT_RD: begin
        state_d = kt_pkg::S_SORT_CMP;
      end
      kt_pkg::S_SORT_CMP: begin
        we    = 1'b1;
        waddr = AW'(j_q - 1'b1);
        if ($signed(cur_q) > $signed(rdata)) begin
          wdata = rdata;
        end else begin
          wdata = cur_q;
          cur_d = rdata;
        end
        if (j_q + 1'b1 < cnt_q) begin
          j_d = j_q + 1'b1;
          state_d = kt_pkg::S_SORT_RD;
        end else begin
          state_d = kt_pkg::S_SORT_LAST;
        end
      end
      kt_pkg::S_SORT_LAST: begin
        we    = 1'b1;
        waddr = AW'(cnt_q - 1'b1);
        wdata = cur_q;
        pass_d = pass_q + 1'b1;
        state_d = (pass_q + 1'b1 < cnt_q - 1'b1) ? kt_pkg::S_SORT_RD0 : kt_pkg::S_DONE;
      end
      kt_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_d       = res_q;
          out_d.count = 6'(cnt_q);
          out_valid_d = 1'b1;
          state_d     = kt_pkg::S_IDLE;
        end
      end
      default: state_d = kt_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("entry count above depth");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != kt_pkg::S_IDLE)
    else $error("sequencer idle right after a transfer");
  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == kt_pkg::S_INS_WR |-> cnt_q < DepthC)
    else $error("insert into a full table");
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kt_pkg::S_DONE && !out_valid_q) |=> out_valid_q)
    else $error("finished result not presented");
`endif
endmodule
`default_nettype wire

/* hdl/kt_ram.sv */
// kt_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module kt_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* tb/sv/key_table_insert_remove_sort_top_test.sv */
// key_table_insert_remove_sort_top_test: self-checking bench for the key table block
// drives operations on s_axis, predicts each result and compares what leaves m_axis
// depends on kt_pkg and key_table_insert_remove_sort_top
`default_nettype none
module key_table_insert_remove_sort_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;

  typedef struct packed {
    logic        found;
    logic [5:0]  position;
    logic [31:0] value;
    logic [5:0]  count;
    logic [1:0]  status;
  } outcome_t;

  // one row of the directed table; chk set means the typed-in result is compared too
  typedef struct {
    logic [2:0]  fn;
    logic [31:0] k;
    logic [31:0] nk;
    logic [4:0]  idx;
    logic        clr;
    bit          chk;
    outcome_t    want;
  } op_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // key[31:0], new_key[63:32], index[68:64], clear_first[69], zero fill
  logic [71:0] s_axis_tdata_i = '0;
  // func[2:0]
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // found[0], position[6:1], value[38:7], count[44:39], status[46:45], zero fill
  logic [47:0] m_axis_tdata_o;

  key_table_insert_remove_sort_top #(.DEPTH(DEPTH)) dut (.*);

  // predictor state: the table contents and the number of valid keys
  logic [31:0] keys_q [DEPTH];
  int          nkeys;
  outcome_t    pending_results [$];
  outcome_t    typed_results [$];
  bit          typed_flags [$];
  int          errors = 0;
  bit          sender_done = 0;
  bit          rx_busy_mode = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // compute the result of one operation and update the shadow table
  function automatic outcome_t apply_key_op(logic [2:0] fn, logic [31:0] k,
                                            logic [31:0] nk, logic [4:0] idx,
                                            logic clr);
    outcome_t r;
    int hit;
    logic [31:0] v;
    int j;
    r = '0;
    case (fn)
      kt_pkg::FN_APPEND: begin
        if (clr) nkeys = 0;
        r.position = nkeys[5:0];
        if (nkeys >= DEPTH) begin
          r.status = kt_pkg::ST_FULL;
        end else begin
          keys_q[nkeys] = k;
          r.value = k;
          nkeys++;
        end
      end
      kt_pkg::FN_READ: begin
        r.position = {1'b0, idx};
        if (idx < nkeys) r.value = keys_q[idx];
        else r.status = kt_pkg::ST_RANGE;
      end
      kt_pkg::FN_SEARCH, kt_pkg::FN_REMOVE, kt_pkg::FN_INSERT: begin
        hit = -1;
        for (int i = 0; i < nkeys; i++) begin
          if (hit < 0 && keys_q[i] == k) hit = i;
        end
        if (hit < 0) begin
          r.status = kt_pkg::ST_NOT_FOUND;
        end else begin
          r.found = 1'b1;
          r.position = hit[5:0];
          r.value = k;
          if (fn == kt_pkg::FN_REMOVE) begin
            for (int i = hit; i + 1 < nkeys; i++) keys_q[i] = keys_q[i + 1];
            nkeys--;
          end else if (fn == kt_pkg::FN_INSERT) begin
            if (nkeys >= DEPTH) begin
              r.status = kt_pkg::ST_FULL;
            end else begin
              for (int i = nkeys; i > hit; i--) keys_q[i] = keys_q[i - 1];
              keys_q[hit] = nk;
              nkeys++;
            end
          end
        end
      end
      kt_pkg::FN_SORT: begin
        for (int i = 1; i < nkeys; i++) begin
          v = keys_q[i];
          j = i;
          while (j > 0 && $signed(keys_q[j - 1]) > $signed(v)) begin
            keys_q[j] = keys_q[j - 1];
            j--;
          end
          keys_q[j] = v;
        end
      end
      default: ;
    endcase
    r.count = nkeys[5:0];
    return r;
  endfunction

  // short gaps mostly, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one transfer on s_axis; prediction happens at the accepting edge
  task automatic send_key_op(logic [2:0] fn, logic [31:0] k, logic [31:0] nk,
                             logic [4:0] idx, logic clr, bit chk, outcome_t want);
    repeat (pick_gap() + 1) @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= fn;
    s_axis_tdata_i  <= {2'b00, clr, idx, nk, k};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(apply_key_op(fn, k, nk, idx, clr));
    typed_results.push_back(want);
    typed_flags.push_back(chk);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  // receiver: random stalls, with stretches of none
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 199) == 0) rx_busy_mode = ~rx_busy_mode;
      m_axis_tready_i <= rx_busy_mode ? 1'b1 : (pick_gap() == 0);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    outcome_t got, exp_r, typed;
    bit tchk;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[0], m_axis_tdata_o[6:1], m_axis_tdata_o[38:7],
             m_axis_tdata_o[44:39], m_axis_tdata_o[46:45]};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        typed = typed_results.pop_front();
        tchk = typed_flags.pop_front();
        if (got.found !== exp_r.found) begin
          $display("%0t: found exp %0d got %0d", $realtime, exp_r.found, got.found);
          errors++;
        end
        if (got.position !== exp_r.position) begin
          $display("%0t: position exp %0d got %0d", $realtime, exp_r.position,
                   got.position);
          errors++;
        end
        if (got.value !== exp_r.value) begin
          $display("%0t: value exp %h got %h", $realtime, exp_r.value, got.value);
          errors++;
        end
        if (got.count !== exp_r.count) begin
          $display("%0t: count exp %0d got %0d", $realtime, exp_r.count, got.count);
          errors++;
        end
        if (got.status !== exp_r.status) begin
          $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, got.status);
          errors++;
        end
        // typed-in rows also guard the predictor itself
        if (tchk && typed !== exp_r) begin
          $display("%0t: table row exp %h predicted %h", $realtime, typed, exp_r);
          errors++;
        end
      end
    end
  end

  // random key drawn from a small pool so matches are common, with extremes mixed in
  function automatic logic [31:0] pick_key();
    int p;
    p = $urandom_range(0, 9);
    if (p < 6) return $urandom_range(0, 12) - 6;
    if (p == 6) return 32'h8000_0000;
    if (p == 7) return 32'h7fff_ffff;
    return $urandom;
  endfunction

  // stimulus
  initial begin
    op_row_t rows [$];
    op_row_t row;
    outcome_t w;
    logic [2:0] fn;
    int p;
    int budget;
    nkeys = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part; expected results typed in where obvious
    row = '{fn: kt_pkg::FN_READ, k: '0, nk: '0, idx: 5'd0, clr: 0, chk: 1,
            want: '{1'b0, 6'd0, 32'd0, 6'd0, kt_pkg::ST_RANGE}};
    rows.push_back(row);
    row = '{kt_pkg::FN_SEARCH, 32'd5, '0, '0, 0, 1,
            '{1'b0, 6'd0, 32'd0, 6'd0, kt_pkg::ST_NOT_FOUND}};
    rows.push_back(row);
    row = '{kt_pkg::FN_SORT, '0, '0, '0, 0, 1, '{1'b0, 6'd0, 32'd0, 6'd0, kt_pkg::ST_OK}};
    rows.push_back(row);
    row = '{kt_pkg::FN_APPEND, 32'h7fff_ffff, '0, '0, 1, 1,
            '{1'b0, 6'd0, 32'h7fff_ffff, 6'd1, kt_pkg::ST_OK}};
    rows.push_back(row);
    row = '{kt_pkg::FN_APPEND, 32'h8000_0000, '0, '0, 0, 1,
            '{1'b0, 6'd1, 32'h8000_0000, 6'd2, kt_pkg::ST_OK}};
    rows.push_back(row);
    row = '{kt_pkg::FN_APPEND, 32'hffff_ffff, '0, '0, 0, 0, '0};
    rows.push_back(row);
    row = '{kt_pkg::FN_READ, '0, '0, 5'd31, 0, 1,
            '{1'b0, 6'd31, 32'd0, 6'd3, kt_pkg::ST_RANGE}};
    rows.push_back(row);
    row = '{kt_pkg::FN_INSERT, 32'h8000_0000, 32'hffff_ffff, '0, 0, 0, '0};
    rows.push_back(row);
    row = '{kt_pkg::FN_REMOVE, 32'hffff_ffff, '0, '0, 0, 0, '0};
    rows.push_back(row);
    row = '{kt_pkg::FN_SORT, '0, '0, '0, 0, 0, '0};
    rows.push_back(row);
    row = '{kt_pkg::FN_READ, '0, '0, 5'd0, 0, 0, '0};
    rows.push_back(row);
    row = '{kt_pkg::FN_REMOVE, 32'h1234_5678, '0, '0, 0, 1,
            '{1'b0, 6'd0, 32'd0, 6'd3, kt_pkg::ST_NOT_FOUND}};
    rows.push_back(row);
    row = '{kt_pkg::FN_INSERT, 32'h1234_5678, 32'd1, '0, 0, 1,
            '{1'b0, 6'd0, 32'd0, 6'd3, kt_pkg::ST_NOT_FOUND}};
    rows.push_back(row);
    row = '{3'd6, '0, '0, '0, 0, 1, '{1'b0, 6'd0, 32'd0, 6'd3, kt_pkg::ST_OK}};
    rows.push_back(row);
    row = '{3'd7, 32'hffff_ffff, 32'hffff_ffff, 5'd31, 1, 1,
            '{1'b0, 6'd0, 32'd0, 6'd3, kt_pkg::ST_OK}};
    rows.push_back(row);
    foreach (rows[i])
      send_key_op(rows[i].fn, rows[i].k, rows[i].nk, rows[i].idx, rows[i].clr,
                  rows[i].chk, rows[i].want);

    // fill to full, then the table-full cases and a full-table sort
    w = '0;
    send_key_op(kt_pkg::FN_APPEND, 32'd3, '0, '0, 1, 0, w);
    for (int i = 1; i < DEPTH; i++) send_key_op(kt_pkg::FN_APPEND, $urandom, '0, '0, 0, 0, w);
    send_key_op(kt_pkg::FN_APPEND, 32'd9, '0, '0, 0, 1,
                '{1'b0, 6'd32, 32'd0, 6'd32, kt_pkg::ST_FULL});
    send_key_op(kt_pkg::FN_INSERT, 32'd3, 32'd1, '0, 0, 1,
                '{1'b1, 6'd0, 32'd3, 6'd32, kt_pkg::ST_FULL});
    send_key_op(kt_pkg::FN_READ, '0, '0, 5'd31, 0, 0, w);
    send_key_op(kt_pkg::FN_SORT, '0, '0, '0, 0, 0, w);

    // sender holds off until every result is back
    wait (pending_results.size() == 0);

    // random part: mostly small tables, occasionally clearing
    budget = 900;
    while (budget > 0) begin
      p = $urandom_range(0, 99);
      if (nkeys < 3 || p < 25) fn = kt_pkg::FN_APPEND;
      else if (p < 40) fn = kt_pkg::FN_READ;
      else if (p < 55) fn = kt_pkg::FN_SEARCH;
      else if (p < 70) fn = kt_pkg::FN_REMOVE;
      else if (p < 85) fn = kt_pkg::FN_INSERT;
      else if (p < 95) fn = kt_pkg::FN_SORT;
      else fn = 3'($urandom_range(6, 7));
      send_key_op(fn, pick_key(), $urandom, 5'($urandom), (fn == kt_pkg::FN_APPEND) ?
                  ($urandom_range(0, 19) == 0) : 1'($urandom_range(0, 1)), 0, w);
      budget--;
      if (budget == 450) wait (pending_results.size() == 0);
    end
    sender_done = 1;
  end

  // end of run
  initial begin
    wait (sender_done);
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog: far beyond the slowest run of full-table sorts and long stalls
  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
